[rtl/sal_pkg.sv]
`default_nettype none

package sal_pkg;

  localparam int DIM_W       = 8;
  localparam int PAGE_IDX_W  = 6;
  localparam int POS_W       = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } sal_req_t;

  typedef struct packed {
    status_t               status;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
  } sal_res_t;

endpackage

`default_nettype wire

[rtl/skyline_atlas_allocator_core.sv]
// Skyline atlas allocator: packs rectangles into PAGE_COUNT pages of PAGE_WIDTH columns, each
// column holding its filled height in one single-port-read column RAM. One item is in flight
// at a time; in_tready is high only while the sequencer is idle. A clear beat wipes the RAM one
// entry per cycle, and the same wipe runs after reset before the first beat is taken. An
// allocate beat prepares and scans each page that it visits, reading one column per cycle,
// then checks the fit and, when placed, writes rect_width columns; the scan restarts past a
// blocking column or past the tallest column of the last best window, so it reads near
// PAGE_WIDTH columns per page and at most about PAGE_WIDTH*rect_width on a page whose heights
// fall column by column. Widths of PAGE_WIDTH or more and a width of zero answer without a
// scan. A finished result sits in the output register while the next beat enters.
`default_nettype none

module skyline_atlas_allocator_core #(
  parameter int PAGE_WIDTH = 128,
  parameter int PAGE_HEIGHT = 128,
  parameter int PAGE_COUNT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sal_pkg::IN_TDATA_W-1:0]    in_tdata,   // rect_width, rect_height
  input  logic [0:0]                        in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sal_pkg::OUT_TDATA_W-1:0]   out_tdata,  // page_index, pos_x, pos_y, zero pad
  output logic [0:0]                        out_tuser   // status
);

  localparam int DEPTH = PAGE_COUNT * PAGE_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int PADW  = sal_pkg::OUT_TDATA_W - sal_pkg::PAGE_IDX_W - 2 * sal_pkg::POS_W;

  sal_pkg::sal_req_t req;
  sal_pkg::sal_res_t res;
  sal_pkg::sal_res_t out_res_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              start;
  logic              seq_ready;
  logic              res_valid;
  logic              res_ack;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [HW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [HW-1:0]     mem_rdata;

  assign req.func        = sal_pkg::func_t'(in_tuser[0]);
  assign req.rect_width  = in_tdata[7:0];
  assign req.rect_height = in_tdata[15:8];

  assign in_tready = seq_ready;
  assign start     = in_tvalid & seq_ready;

  // result moves into the output register when it is empty or draining this beat
  assign res_ack = res_valid & (~out_tvalid_r | out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_ack) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_res_r.pos_y, out_res_r.pos_x, out_res_r.page_index};
  assign out_tuser  = out_res_r.status;

  sal_seq #(
    .PAGE_WIDTH (PAGE_WIDTH),
    .PAGE_HEIGHT(PAGE_HEIGHT),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .ready    (seq_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_ack  (res_ack),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  sal_col_ram #(
    .DEPTH(DEPTH),
    .DW   (HW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

[rtl/sal_col_ram.sv]
`default_nettype none

module sal_col_ram #(
  parameter int DEPTH = 8192,
  parameter int DW = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/sal_seq.sv]
`default_nettype none

module sal_seq #(
  parameter int PAGE_WIDTH = 128,
  parameter int PAGE_HEIGHT = 128,
  parameter int PAGE_COUNT = 64,
  localparam int DEPTH = PAGE_COUNT * PAGE_WIDTH,
  localparam int AW = $clog2(DEPTH),
  localparam int HW = $clog2(PAGE_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sal_pkg::sal_req_t req,
  output logic              ready,
  output logic              res_valid,
  output sal_pkg::sal_res_t res,
  input  logic              res_ack,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [HW-1:0]     mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [HW-1:0]     mem_rdata
);

  localparam int CW  = $clog2(PAGE_WIDTH);
  localparam int NW  = CW + 1;
  localparam int PGW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SW  = ((HW > sal_pkg::DIM_W) ? HW : sal_pkg::DIM_W) + 1;
  localparam int DW  = sal_pkg::DIM_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WIPE  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_FIT   = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } seq_state_t;

  seq_state_t     state_r, state_nxt;
  logic           clr_r, clr_nxt;
  logic           full_r, full_nxt;
  logic           found_r, found_nxt;
  logic [AW-1:0]  wipe_r, wipe_nxt;
  logic [DW-1:0]  w_r, w_nxt;
  logic [DW-1:0]  h_r, h_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [NW-1:0]  lim_r, lim_nxt;
  logic [PGW-1:0] page_r, page_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [CW-1:0]  x_r, x_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [CW-1:0]  topp_r, topp_nxt;
  logic [CW-1:0]  bx_r, bx_nxt;
  logic [HW-1:0]  top_r, top_nxt;
  logic [HW-1:0]  best_r, best_nxt;
  logic [HW-1:0]  newh_r, newh_nxt;

  logic           fail;
  logic           take;
  logic [HW-1:0]  top_c;
  logic [CW-1:0]  topp_c;
  logic [NW-1:0]  nx_fail;
  logic [NW-1:0]  nx_succ;
  logic [SW-1:0]  sum;
  logic           fit;
  logic           last_page;
  logic           wipe_last;
  logic           zero_res;
  logic [31:0]    page_wide;
  logic [31:0]    bx_wide;
  logic [31:0]    best_wide;

  // one compare/max step per column beat
  assign fail    = mem_rdata >= best_r;
  assign take    = mem_rdata >= top_r;
  assign top_c   = take ? mem_rdata : top_r;
  assign topp_c  = take ? j_r : topp_r;
  assign nx_fail = NW'(j_r) + NW'(1);
  // any window holding the max column cannot beat it, so restart past it
  assign nx_succ = NW'(topp_c) + NW'(1);

  assign sum       = SW'(best_r) + SW'(h_r);
  assign fit       = found_r && (sum <= SW'(PAGE_HEIGHT));
  assign last_page = page_r == PGW'(PAGE_COUNT - 1);
  assign wipe_last = wipe_r == AW'(DEPTH - 1);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    full_nxt  = full_r;
    found_nxt = found_r;
    wipe_nxt  = wipe_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    rem_nxt   = rem_r;
    lim_nxt   = lim_r;
    page_nxt  = page_r;
    base_nxt  = base_r;
    x_nxt     = x_r;
    j_nxt     = j_r;
    topp_nxt  = topp_r;
    bx_nxt    = bx_r;
    top_nxt   = top_r;
    best_nxt  = best_r;
    newh_nxt  = newh_r;
    mem_we    = 1'b0;
    mem_waddr = base_r + AW'(j_r);
    mem_wdata = newh_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          w_nxt    = req.rect_width;
          h_nxt    = req.rect_height;
          lim_nxt  = NW'(PAGE_WIDTH - int'(req.rect_width));
          clr_nxt  = 1'b0;
          full_nxt = 1'b0;
          page_nxt = '0;
          base_nxt = '0;
          bx_nxt   = '0;
          best_nxt = '0;
          priority if (req.func == sal_pkg::FUNC_CLEAR) begin
            clr_nxt   = 1'b1;
            wipe_nxt  = '0;
            state_nxt = S_WIPE;
          end else if (32'(req.rect_width) >= PAGE_WIDTH) begin
            full_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else if (req.rect_width == '0) begin
            // every empty window ties at height zero, the last start tried wins
            bx_nxt    = CW'(PAGE_WIDTH - 1);
            full_nxt  = 32'(req.rect_height) > PAGE_HEIGHT;
            state_nxt = S_DONE;
          end else begin
            best_nxt  = HW'(PAGE_HEIGHT);
            found_nxt = 1'b0;
            x_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_LOAD;
          end
        end
      end

      S_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_r;
        mem_wdata = '0;
        wipe_nxt  = wipe_r + AW'(1);
        if (wipe_last) begin
          state_nxt = clr_r ? S_DONE : S_IDLE;
        end
      end

      S_LOAD: begin
        rem_nxt   = w_r - DW'(1);
        top_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (fail) begin
          if (nx_fail < lim_r) begin
            x_nxt   = CW'(nx_fail);
            j_nxt   = CW'(nx_fail);
            rem_nxt = w_r - DW'(1);
            top_nxt = '0;
          end else begin
            state_nxt = S_FIT;
          end
        end else begin
          top_nxt  = top_c;
          topp_nxt = topp_c;
          if (rem_r == '0) begin
            best_nxt  = top_c;
            bx_nxt    = x_r;
            found_nxt = 1'b1;
            // height zero can not be beaten
            if (top_c != '0 && nx_succ < lim_r) begin
              x_nxt   = CW'(nx_succ);
              j_nxt   = CW'(nx_succ);
              rem_nxt = w_r - DW'(1);
              top_nxt = '0;
            end else begin
              state_nxt = S_FIT;
            end
          end else begin
            j_nxt   = j_r + CW'(1);
            rem_nxt = rem_r - DW'(1);
          end
        end
      end

      S_FIT: begin
        newh_nxt = HW'(sum);
        priority if (fit) begin
          j_nxt     = bx_r;
          rem_nxt   = w_r - DW'(1);
          state_nxt = S_WRITE;
        end else if (last_page) begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          page_nxt  = page_r + PGW'(1);
          base_nxt  = base_r + AW'(PAGE_WIDTH);
          best_nxt  = HW'(PAGE_HEIGHT);
          found_nxt = 1'b0;
          x_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_LOAD;
        end
      end

      S_WRITE: begin
        mem_we  = 1'b1;
        j_nxt   = j_r + CW'(1);
        rem_nxt = rem_r - DW'(1);
        if (rem_r == '0) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read address is column j_nxt of this page; the RAM registers it, so mem_rdata holds column j_r
  assign mem_raddr = base_r + AW'(j_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      wipe_r  <= '0;
      clr_r   <= 1'b0;
      full_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wipe_r  <= wipe_nxt;
      clr_r   <= clr_nxt;
      full_r  <= full_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    rem_r  <= rem_nxt;
    lim_r  <= lim_nxt;
    page_r <= page_nxt;
    base_r <= base_nxt;
    x_r    <= x_nxt;
    j_r    <= j_nxt;
    topp_r <= topp_nxt;
    bx_r   <= bx_nxt;
    top_r  <= top_nxt;
    best_r <= best_nxt;
    newh_r <= newh_nxt;
  end

  assign ready     = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;

  assign zero_res  = full_r | clr_r;
  assign page_wide = 32'(page_r);
  assign bx_wide   = 32'(bx_r);
  assign best_wide = 32'(best_r);

  always_comb begin
    res.status     = full_r ? sal_pkg::STATUS_FULL : sal_pkg::STATUS_OK;
    res.page_index = zero_res ? '0 : page_wide[sal_pkg::PAGE_IDX_W-1:0];
    res.pos_x      = zero_res ? '0 : bx_wide[sal_pkg::POS_W-1:0];
    res.pos_y      = zero_res ? '0 : best_wide[sal_pkg::POS_W-1:0];
  end

`ifndef SYNTHESIS
  a_found_below: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> best_r < HW'(PAGE_HEIGHT))
    else $error("found window not below page height");

  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (j_r >= x_r && NW'(x_r) < lim_r))
    else $error("scan column outside a legal window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (found_r && newh_r <= HW'(PAGE_HEIGHT) && newh_r >= best_r))
    else $error("fill height out of range");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r != S_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ack) |=> state_r == S_DONE)
    else $error("result dropped before it was taken");
`endif

endmodule

`default_nettype wire

[tb/sv/skyline_atlas_allocator_core_tb.sv]
`default_nettype none

module skyline_atlas_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PG_W      = 128;
  localparam int PG_H      = 128;
  localparam int N_PAGES   = 64;
  localparam int QUIET_MAX = 2000000;
  localparam int HOLD_LEN  = 2000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sal_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sal_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;

  skyline_atlas_allocator_core #(
    .PAGE_WIDTH (PG_W),
    .PAGE_HEIGHT(PG_H),
    .PAGE_COUNT (N_PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // predictor state: filled height of every column of every page
  int unsigned col_h [N_PAGES][PG_W];

  sal_pkg::sal_req_t req_q[$];
  sal_pkg::sal_res_t expected_places[$];

  int err_cnt = 0;
  int res_cnt = 0;
  int gap_left = 0;
  int calm_in = 0;
  int stall_left = 0;
  int calm_out = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int quiet_cycles = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 120);
  endfunction

  function automatic sal_pkg::sal_res_t place_rect(sal_pkg::func_t fn, int w, int h);
    sal_pkg::sal_res_t res;
    int best, bx, top;
    bit found, ok;
    res = '0;
    if (fn == sal_pkg::FUNC_CLEAR) begin
      for (int p = 0; p < N_PAGES; p++)
        for (int c = 0; c < PG_W; c++)
          col_h[p][c] = 0;
      return res;
    end
    for (int p = 0; p < N_PAGES; p++) begin
      best = PG_H;
      bx = 0;
      found = 1'b0;
      // the start column PG_W-w is left out on purpose
      for (int x = 0; x + w < PG_W; x++) begin
        top = 0;
        ok = 1'b1;
        for (int k = 0; k < w; k++) begin
          if (col_h[p][x+k] >= best) begin
            ok = 1'b0;
            break;
          end
          if (col_h[p][x+k] > top) top = col_h[p][x+k];
        end
        if (ok) begin
          best = top;
          bx = x;
          found = 1'b1;
        end
      end
      if (found && best + h <= PG_H) begin
        for (int k = 0; k < w; k++)
          col_h[p][bx+k] = best + h;
        res.page_index = p[sal_pkg::PAGE_IDX_W-1:0];
        res.pos_x = bx[sal_pkg::POS_W-1:0];
        res.pos_y = best[sal_pkg::POS_W-1:0];
        return res;
      end
    end
    res.status = sal_pkg::STATUS_FULL;
    return res;
  endfunction

  task automatic push_req(sal_pkg::func_t fn, int w, int h);
    sal_pkg::sal_req_t rq;
    rq.func = fn;
    rq.rect_width = w[sal_pkg::DIM_W-1:0];
    rq.rect_height = h[sal_pkg::DIM_W-1:0];
    req_q.push_back(rq);
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // input driver: predicts on every accepted beat, then loads the next one
  always @(posedge clk) begin : drive_in
    sal_pkg::sal_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_places.push_back(place_rect(sal_pkg::func_t'(in_tuser[0]),
                                             int'(in_tdata[7:0]), int'(in_tdata[15:8])));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          nxt = req_q.pop_front();
          in_tdata <= {nxt.rect_height, nxt.rect_width};
          in_tuser <= nxt.func;
          in_tvalid <= 1'b1;
          if (calm_in > 0) begin
            calm_in--;
          end else begin
            gap_left = idle_len();
            if ($urandom_range(0, 19) == 0) calm_in = $urandom_range(10, 30);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold-off so the core backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held_once && res_cnt >= 30) begin
      held_once = 1'b1;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (calm_out > 0) begin
        calm_out--;
      end else begin
        stall_left = idle_len();
        if ($urandom_range(0, 19) == 0) calm_out = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : mon_out
    sal_pkg::sal_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      res_cnt <= res_cnt + 1;
      if (expected_places.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_r = expected_places.pop_front();
        check_field("status", exp_r.status, out_tuser[0]);
        check_field("page_index", exp_r.page_index, out_tdata[5:0]);
        check_field("pos_x", exp_r.pos_x, out_tdata[12:6]);
        check_field("pos_y", exp_r.pos_y, out_tdata[19:13]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    // directed: width limits, empty rectangles, page skipping, full pages, clear
    push_req(sal_pkg::FUNC_ALLOC, 1, 1);
    push_req(sal_pkg::FUNC_ALLOC, 128, 1);
    push_req(sal_pkg::FUNC_ALLOC, 127, 128);
    push_req(sal_pkg::FUNC_ALLOC, 1, 1);
    push_req(sal_pkg::FUNC_ALLOC, 0, 5);
    push_req(sal_pkg::FUNC_ALLOC, 0, 200);
    push_req(sal_pkg::FUNC_CLEAR, 0, 0);
    push_req(sal_pkg::FUNC_ALLOC, 127, 128);
    push_req(sal_pkg::FUNC_ALLOC, 1, 128);
    push_req(sal_pkg::FUNC_ALLOC, 128, 128);
    push_req(sal_pkg::FUNC_ALLOC, 64, 64);
    push_req(sal_pkg::FUNC_ALLOC, 64, 64);
    push_req(sal_pkg::FUNC_ALLOC, 64, 65);
    push_req(sal_pkg::FUNC_ALLOC, 85, 42);
    push_req(sal_pkg::FUNC_ALLOC, 42, 85);
    push_req(sal_pkg::FUNC_ALLOC, 1, 127);
    push_req(sal_pkg::FUNC_ALLOC, 127, 1);
    push_req(sal_pkg::FUNC_ALLOC, 2, 128);
    push_req(sal_pkg::FUNC_ALLOC, 200, 255);
    push_req(sal_pkg::FUNC_ALLOC, 3, 0);
    push_req(sal_pkg::FUNC_CLEAR, 255, 255);
    push_req(sal_pkg::FUNC_ALLOC, 3, 5);
    push_req(sal_pkg::FUNC_ALLOC, 3, 5);
    push_req(sal_pkg::FUNC_ALLOC, 126, 7);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sender pauses here until the core has answered everything
    while (req_q.size() > 0 || in_tvalid || expected_places.size() > 0) @(posedge clk);

    for (int i = 0; i < 80; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        push_req(sal_pkg::FUNC_CLEAR, $urandom_range(1, 128), $urandom_range(1, 128));
      else if (r < 14)
        push_req(sal_pkg::FUNC_ALLOC, $urandom_range(96, 128), $urandom_range(1, 128));
      else if (r < 24)
        push_req(sal_pkg::FUNC_ALLOC, $urandom_range(1, 16), $urandom_range(64, 128));
      else
        push_req(sal_pkg::FUNC_ALLOC, $urandom_range(1, 24), $urandom_range(1, 40));
    end

    while (req_q.size() > 0 || in_tvalid || expected_places.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
